// ----- hw/rtl/cmf_pkg.sv -----
// shared types, constants and helpers of the circular max filter
`timescale 1ns / 1ps
`default_nettype none
package cmf_pkg;
  localparam int MAX_RADIUS   = 32;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int STORE_ROWS   = 2 * MAX_RADIUS + 2;
  localparam int STORE_DEPTH  = STORE_ROWS * MAX_WIDTH;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int SROW_W       = $clog2(STORE_ROWS);
  localparam int ADDR_W       = SROW_W + COL_W;
  localparam int RAD_W        = 6;
  localparam int WID_W        = 11;
  localparam int HGT_W        = 13;
  localparam int OROW_W       = 12;
  localparam int SEEN_W       = 23;
  localparam int OFS_W        = $clog2(MAX_RADIUS + 1) + 1;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              job;
    logic [COL_W-1:0]  ox;
    logic [OROW_W-1:0] oy;
    logic [SROW_W-1:0] oys;
    logic              last;
  } q_entry_t;

  typedef enum logic [1:0] {BK_IDLE, BK_SCAN, BK_DRAIN, BK_DONE} bk_state_t;

  function automatic logic [31:0] order_key(input logic [31:0] b);
    return b[31] ? ~b : (b ^ 32'h8000_0000);
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/circular_max_filter.sv -----
// top level: register port, front end, queue and scan back end
// a result follows its causing item through the queue and a disk scan of the store
// results are paced by the disk scan through the single store read port
// reset: counters cleared, radius 26, width 1024, height 1024; store content undefined
`timescale 1ns / 1ps
`default_nettype none
module circular_max_filter (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         opcode,
  input  wire  [31:0] pixel_value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] max_value,
  output logic        frame_last
);
  import cmf_pkg::*;

  logic [RAD_W-1:0] disk_radius;
  logic [WID_W-1:0] frame_width;
  logic [HGT_W-1:0] frame_height;
  logic             wr_xfer, cfg_clear, q_push, q_full, q_pop, q_valid;
  cfg_t             cfg;
  q_entry_t         q_in, q_out;

  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;
  // counters restart on the same edge that writes a register
  assign cfg_clear = wr_xfer && (paddr[3:2] == REG_RADIUS || paddr[3:2] == REG_WIDTH ||
                                 paddr[3:2] == REG_HEIGHT);

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS: prdata = {26'b0, disk_radius};
      REG_WIDTH:  prdata = {21'b0, frame_width};
      REG_HEIGHT: prdata = {19'b0, frame_height};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_radius  <= RAD_W'(26);
      frame_width  <= WID_W'(1024);
      frame_height <= HGT_W'(1024);
    end else begin
      if (wr_xfer) begin
        case (paddr[3:2])
          REG_RADIUS: disk_radius  <= pwdata[RAD_W-1:0];
          REG_WIDTH:  frame_width  <= pwdata[WID_W-1:0];
          REG_HEIGHT: frame_height <= pwdata[HGT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // register values clamped to the supported ranges
  assign cfg.radius = (disk_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : disk_radius;
  assign cfg.width  = (frame_width == '0) ? WID_W'(1)
                    : (frame_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : frame_width;
  assign cfg.height = (frame_height == '0) ? HGT_W'(1)
                    : (frame_height > HGT_W'(HEIGHT_LIMIT)) ? HGT_W'(HEIGHT_LIMIT)
                    : frame_height;

  cmf_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .cfg_clear(cfg_clear),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .pixel_value(pixel_value),
    .q_push(q_push), .q_entry(q_in), .q_full(q_full)
  );

  cmf_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .not_empty(q_valid)
  );

  cmf_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_entry(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .max_value(max_value),
    .frame_last(frame_last)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/cmf_front.sv -----
// front end: position counters, store write and output job classification
`timescale 1ns / 1ps
`default_nettype none
module cmf_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire cmf_pkg::cfg_t    cfg,
  input  wire                   cfg_clear,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   opcode,
  input  wire  [31:0]           pixel_value,
  output logic                  q_push,
  output cmf_pkg::q_entry_t     q_entry,
  input  wire                   q_full
);
  import cmf_pkg::*;

  logic [COL_W-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [HGT_W-1:0]  in_row, in_row_next;
  logic [OROW_W-1:0] out_row, out_row_next;
  logic [SROW_W-1:0] in_srow, in_srow_next, out_srow, out_srow_next;
  logic [SEEN_W-1:0] seen, seen_next;
  logic [16:0]       lat;
  logic              accept, act, wr, job, last, clr;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign lat      = 17'(cfg.radius) * 17'(cfg.width) + 17'(cfg.radius);

  always_comb begin
    in_col_next   = in_col;
    in_row_next   = in_row;
    in_srow_next  = in_srow;
    out_col_next  = out_col;
    out_row_next  = out_row;
    out_srow_next = out_srow;
    seen_next     = seen;
    wr   = 1'b0;
    job  = 1'b0;
    last = 1'b0;
    clr  = 1'b0;
    act  = !(in_row < cfg.height && opcode == OP_FLUSH);
    if (act) begin
      wr = in_row < cfg.height;
      if (wr) begin
        if (12'(in_col) + 12'd1 >= 12'(cfg.width)) begin
          in_col_next  = '0;
          in_row_next  = in_row + 1'b1;
          in_srow_next = (in_srow == SROW_W'(STORE_ROWS - 1)) ? '0 : in_srow + 1'b1;
        end else begin
          in_col_next = in_col + 1'b1;
        end
      end
      seen_next = seen + 1'b1;
      if (seen_next > SEEN_W'(lat)) begin
        if (HGT_W'(out_row) >= cfg.height || WID_W'(out_col) >= cfg.width) begin
          clr = 1'b1;
        end else begin
          job  = 1'b1;
          last = (HGT_W'(out_row) == cfg.height - 1'b1) &&
                 (WID_W'(out_col) == cfg.width - 1'b1);
          if (last) begin
            clr = 1'b1;
          end else if (12'(out_col) + 12'd1 >= 12'(cfg.width)) begin
            out_col_next  = '0;
            out_row_next  = out_row + 1'b1;
            out_srow_next = (out_srow == SROW_W'(STORE_ROWS - 1)) ? '0 : out_srow + 1'b1;
          end else begin
            out_col_next = out_col + 1'b1;
          end
        end
      end
    end
  end

  assign q_push        = accept && act && (wr || job);
  assign q_entry.wr    = wr;
  assign q_entry.waddr = {in_srow, in_col};
  assign q_entry.wdata = pixel_value;
  assign q_entry.job   = job;
  assign q_entry.ox    = out_col;
  assign q_entry.oy    = out_row;
  assign q_entry.oys   = out_srow;
  assign q_entry.last  = last;

  always_ff @(posedge clk) begin
    if (rst || cfg_clear || (accept && clr)) begin
      in_col <= '0; in_row <= '0; in_srow <= '0;
      out_col <= '0; out_row <= '0; out_srow <= '0;
      seen <= '0;
    end else if (accept) begin
      in_col <= in_col_next; in_row <= in_row_next; in_srow <= in_srow_next;
      out_col <= out_col_next; out_row <= out_row_next; out_srow <= out_srow_next;
      seen <= seen_next;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/cmf_queue.sv -----
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cmf_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire cmf_pkg::q_entry_t din,
  output logic               full,
  input  wire                pop,
  output cmf_pkg::q_entry_t  dout,
  output logic               not_empty
);
  import cmf_pkg::*;

  q_entry_t   slot [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign dout      = slot[rp];

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/cmf_back.sv -----
// back end: line store and disk scan through one read port
`timescale 1ns / 1ps
`default_nettype none
module cmf_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire cmf_pkg::cfg_t     cfg,
  input  wire                    q_valid,
  input  wire cmf_pkg::q_entry_t q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [31:0]            max_value,
  output logic                   frame_last
);
  import cmf_pkg::*;

  logic [31:0] mem [STORE_DEPTH];

  bk_state_t state, state_next;
  logic [COL_W-1:0]       ox;
  logic [OROW_W-1:0]      oy;
  logic [SROW_W-1:0]      ys;
  logic                   last;
  logic [15:0]            lim;
  logic signed [OFS_W-1:0] dx, dy, rs;
  logic                   rd_en, rd_pend, any, load, start, scan_end;
  logic [ADDR_W-1:0]      rd_addr;
  logic [31:0]            rd_data, best;
  logic [RAD_W-1:0]       adx, ady;
  logic [15:0]            d16;
  logic signed [11:0]     xr, wmax;
  logic [COL_W-1:0]       xc;
  logic signed [13:0]     yt, hmax;
  logic                   qual;

  assign rs   = OFS_W'($signed({1'b0, cfg.radius}));
  assign adx  = dx[OFS_W-1] ? RAD_W'(-dx) : RAD_W'(dx);
  assign ady  = dy[OFS_W-1] ? RAD_W'(-dy) : RAD_W'(dy);
  assign d16  = {(12'(adx) * 12'(adx) + 12'(ady) * 12'(ady)), 4'b0};
  assign qual = d16 < lim;
  assign wmax = $signed({1'b0, cfg.width}) - 12'sd1;
  assign xr   = $signed({2'b0, ox}) + 12'(dx);
  assign xc   = (xr < 0) ? '0 : (xr > wmax) ? COL_W'(wmax) : COL_W'(xr);
  assign rd_addr  = {ys, xc};
  assign scan_end = (dx == rs) && (dy == rs);
  assign hmax = $signed({1'b0, cfg.height}) - 14'sd1;
  assign yt   = $signed({2'b0, oy}) + 14'(dy) + 14'sd1;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (q_valid && q_entry.job) state_next = BK_SCAN;
      BK_SCAN:  if (scan_end) state_next = BK_DRAIN;
      BK_DRAIN: state_next = BK_DONE;
      BK_DONE:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    start = 1'b0;
    rd_en = 1'b0;
    load  = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop = q_valid;
        start = q_valid && q_entry.job;
      end
      BK_SCAN: rd_en = qual;
      BK_DONE: load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.wr) mem[q_entry.waddr] <= q_entry.wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ox   <= q_entry.ox;
      oy   <= q_entry.oy;
      last <= q_entry.last;
      lim  <= 16'((4 * cfg.radius + 1) * (4 * cfg.radius + 1));
      dx   <= -rs;
      dy   <= -rs;
      if (q_entry.oy >= OROW_W'(cfg.radius)) begin
        ys <= (q_entry.oys >= SROW_W'(cfg.radius)) ? q_entry.oys - SROW_W'(cfg.radius)
            : q_entry.oys + SROW_W'(STORE_ROWS) - SROW_W'(cfg.radius);
      end else begin
        ys <= '0;
      end
    end else if (state == BK_SCAN && !scan_end) begin
      if (dx == rs) begin
        dx <= -rs;
        dy <= dy + 1'b1;
        // row moves only while the next row lies inside the plane
        if (yt > 0 && yt <= hmax) begin
          ys <= (ys == SROW_W'(STORE_ROWS - 1)) ? '0 : ys + 1'b1;
        end
      end else begin
        dx <= dx + 1'b1;
      end
    end
    if (rd_pend && (!any || order_key(rd_data) > order_key(best))) best <= rd_data;
    if (load) begin
      max_value  <= best;
      frame_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_pend   <= 1'b0;
      any       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (start) any <= 1'b0;
      else if (rd_pend) any <= 1'b1;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE) |-> !rd_pend)
    else $error("read still in flight at scan end");
  a_done_has_max: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE) |-> any)
    else $error("scan finished with no sample");
  a_rose_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == BK_DONE)
    else $error("result shown outside scan completion");
  a_job_starts: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE && q_valid && q_entry.job) |=> state == BK_SCAN)
    else $error("queued job not started");
endmodule
`default_nettype wire

// ----- tb/sv/cmf_checker.sv -----
// checker for the circular max filter: watches transfers, predicts results and compares
`timescale 1ns / 1ps
`default_nettype none
module cmf_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  input  wire        pready,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire        opcode,
  input  wire [31:0] pixel_value,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [31:0] max_value,
  input  wire        frame_last,
  output int         fail_count,
  output int         pending
);
  import cmf_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } filt_result_t;

  logic [31:0] plane [STORE_DEPTH];
  logic [RAD_W-1:0] radius_reg;
  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;
  int unsigned col_in, row_in, col_out, row_out, seen;
  filt_result_t expected_q[$];
  int mismatches;

  assign fail_count = mismatches;

  function automatic logic [31:0] rank(logic [31:0] b);
    return b[31] ? ~b : {~b[31], b[30:0]};
  endfunction

  function automatic int unsigned slot(int unsigned row, int unsigned col);
    return (row % STORE_ROWS) * MAX_WIDTH + (col % MAX_WIDTH);
  endfunction

  function automatic logic [31:0] disk_peak(int ox, int oy, int r, int w, int h);
    int lim, y, x;
    logic [31:0] best, v;
    logic found;
    lim = (4 * r + 1) * (4 * r + 1);
    found = 0;
    best = '0;
    for (int dy = -r; dy <= r; dy++) begin
      y = oy + dy;
      if (y < 0) y = 0;
      if (y > h - 1) y = h - 1;
      for (int dx = -r; dx <= r; dx++) begin
        if (16 * (dx * dx + dy * dy) >= lim) continue;
        x = ox + dx;
        if (x < 0) x = 0;
        if (x > w - 1) x = w - 1;
        v = plane[slot(y, x)];
        if (!found || rank(v) > rank(best)) begin
          best = v;
          found = 1;
        end
      end
    end
    return best;
  endfunction

  task automatic restart_frame();
    col_in = 0; row_in = 0; col_out = 0; row_out = 0; seen = 0;
  endtask

  task automatic take_item(logic op, logic [31:0] pix);
    int unsigned r, w, h, lat;
    filt_result_t res;
    r = radius_reg > MAX_RADIUS ? MAX_RADIUS : radius_reg;
    w = width_reg < 1 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = height_reg < 1 ? 1 : (height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : height_reg);
    lat = r * w + r;
    if (row_in < h) begin
      // early flush is dropped
      if (op == OP_FLUSH) return;
      plane[slot(row_in, col_in)] = pix;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
    end
    seen++;
    if (seen <= lat) return;
    if (row_out >= h || col_out >= w) begin
      restart_frame();
      return;
    end
    res.last = (row_out == h - 1 && col_out == w - 1);
    res.value = disk_peak(col_out, row_out, r, w, h);
    expected_q.push_back(res);
    if (res.last) restart_frame();
    else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endtask

  always @(posedge clk) begin
    filt_result_t exp_res;
    if (rst) begin
      radius_reg = 26;
      width_reg = 1024;
      height_reg = 1024;
      restart_frame();
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RADIUS: begin radius_reg = pwdata[RAD_W-1:0]; restart_frame(); end
          REG_WIDTH:  begin width_reg = pwdata[WID_W-1:0]; restart_frame(); end
          REG_HEIGHT: begin height_reg = pwdata[HGT_W-1:0]; restart_frame(); end
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_item(opcode, pixel_value);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h last %b", max_value, frame_last);
          mismatches = mismatches + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (exp_res.value !== max_value || exp_res.last !== frame_last) begin
            if (mismatches < 10)
              $display("mismatch: expected %h last %b, got %h last %b",
                       exp_res.value, exp_res.last, max_value, frame_last);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench top: clock, reset, register writes, pixel stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cmf_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic in_valid = 0, opcode = 0;
  logic [31:0] pixel_value = '0;
  wire in_ready, out_valid, frame_last;
  wire [31:0] max_value;
  logic out_ready = 0;
  int fail_count, pending;
  logic calm = 0, hold_off = 0;
  int idle_cycles = 0;
  logic [31:0] corner_vals [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7f7f_ffff,
    32'hff7f_ffff, 32'h7f80_0000, 32'hff80_0000, 32'hffff_ffff, 32'h3e80_0000};

  always #6 clk = ~clk;

  circular_max_filter u_top (.*);

  cmf_checker u_check (.*);

  // receiver: random stalls, quiet stretches, one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (calm) out_ready <= 1;
    else out_ready <= ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready) || penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays high after a transfer until the next idle cycle or drain
  task automatic send_item(logic op, logic [31:0] pix);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 0;
        @(negedge clk);
      end
    end
    in_valid <= 1; opcode <= op; pixel_value <= pix;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4300) @(negedge clk);
  endtask

  task automatic setup(int r, int w, int h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // one full frame plus trailing items of random opcode; without corners an early flush is mixed in
  task automatic run_frame(int w, int h, int r, bit corners);
    int n;
    n = w * h;
    for (int i = 0; i < n; i++) begin
      if (!corners && $urandom_range(15) == 0) send_item(OP_FLUSH, $urandom);
      send_item(OP_PIXEL, corners ? corner_vals[i % 8] : $urandom);
    end
    for (int i = 0; i < r * w + r; i++) send_item($urandom_range(1), $urandom);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    // directed: small frames with edge values and extremes of the registers
    calm = 1;
    setup(1, 3, 3);
    run_frame(3, 3, 1, 1);
    drain();
    setup(0, 1, 1);
    send_item(OP_FLUSH, 32'h1234_5678);
    send_item(OP_PIXEL, 32'hffff_ffff);
    send_item(OP_FLUSH, 32'h0);
    drain();
    // out-of-range registers saturate or clamp
    setup(63, 0, 0);
    send_item(OP_PIXEL, 32'h8000_0000);
    for (int i = 0; i < 64; i++) send_item(OP_FLUSH, 0);
    drain();
    setup(32, 2047, 8191);
    setup(2, 1, 4);
    run_frame(1, 4, 2, 0);
    drain();
    calm = 0;
    // random frames
    for (int f = 0; f < 3; f++) begin
      int r, w, h;
      r = $urandom_range(3);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if (f == 1) begin
        r = 1;
        w = 6;
        h = 4;
      end
      setup(r, w, h);
      if (f == 1) begin
        // hold the receiver off long enough to back up the block
        fork
          begin hold_off = 1; repeat (300) @(negedge clk); hold_off = 0; end
          run_frame(w, h, r, 0);
        join
      end else run_frame(w, h, r, 0);
      drain();
    end
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
